// ----- hw/rtl/sqll_pkg.sv -----
`default_nettype none

package sqll_pkg;

    localparam logic [15:0] MAX_COLUMNS = 16'hFFFF;
    localparam int KW_BYTES = 7;
    localparam int KW_COUNT = 23;
    localparam int RES_MAX = 3;
    localparam int Q_DEPTH = 4;

    typedef logic [15:0] col_t;
    typedef logic [0:KW_BYTES-1][7:0] kw_buf_t;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_DQ,
        MODE_SQ,
        MODE_OP
    } lex_mode_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_BANG,
        OP_LT,
        OP_GT
    } pend_op_t;

    localparam logic [4:0] K_KW      = 5'd0;
    localparam logic [4:0] K_ID      = 5'd1;
    localparam logic [4:0] K_NUM     = 5'd2;
    localparam logic [4:0] K_STR     = 5'd3;
    localparam logic [4:0] K_COMMA   = 5'd4;
    localparam logic [4:0] K_SEMI    = 5'd5;
    localparam logic [4:0] K_LPAREN  = 5'd6;
    localparam logic [4:0] K_RPAREN  = 5'd7;
    localparam logic [4:0] K_EQ      = 5'd8;
    localparam logic [4:0] K_NEQ     = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_GT      = 5'd11;
    localparam logic [4:0] K_PLUS    = 5'd12;
    localparam logic [4:0] K_MINUS   = 5'd13;
    localparam logic [4:0] K_STAR    = 5'd14;
    localparam logic [4:0] K_SLASH   = 5'd15;
    localparam logic [4:0] K_GTEQ    = 5'd16;
    localparam logic [4:0] K_LTEQ    = 5'd17;
    localparam logic [4:0] K_INVALID = 5'd18;
    localparam logic [4:0] K_EOF     = 5'd19;
    localparam logic [4:0] K_ERR     = 5'd20;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_BANG     = 3'd2;
    localparam logic [2:0] ERR_BANG_END = 3'd3;
    localparam logic [2:0] ERR_OPEN_STR = 3'd4;

    typedef struct packed {
        lex_mode_t mode;
        pend_op_t  op;
        col_t      col;
        col_t      start;
        col_t      len;
        logic      ovf;
    } lex_state_t;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [4:0] keyword_id;
        col_t       start_col;
        col_t       text_len;
        logic [2:0] error_code;
        col_t       error_col;
        logic       last_result;
    } token_t;

    // Keywords padded with spaces to the buffer length; only the first
    // KW_LEN bytes take part in a compare.
    localparam kw_buf_t KW_TEXT [KW_COUNT] = '{
        "SELECT ", "FROM   ", "WHERE  ", "ORDER  ", "BY     ", "AND    ",
        "OR     ", "CREATE ", "TABLE  ", "INT    ", "PRIMARY", "KEY    ",
        "VARCHAR", "BOOL   ", "UPDATE ", "SET    ", "INSERT ", "INTO   ",
        "VALUES ", "TRUE   ", "FALSE  ", "DELETE ", "DROP   "
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd5, 3'd2, 3'd3, 3'd2, 3'd6, 3'd5, 3'd3, 3'd7, 3'd3,
        3'd7, 3'd4, 3'd6, 3'd3, 3'd6, 3'd4, 3'd6, 3'd4, 3'd5, 3'd6, 3'd4
    };

    function automatic col_t sat_inc(input col_t v);
        return (v == MAX_COLUMNS) ? v : col_t'(v + 16'd1);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? 8'(c - 8'd32) : c;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "=":     k = K_EQ;
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            default: k = K_KW;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] kw_lookup(input kw_buf_t b, input col_t len,
                                             input logic ovf);
        logic [4:0] id;
        logic       hit;
        id = 5'd0;
        if (!ovf && len <= col_t'(KW_BYTES)) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                hit = (len == {13'd0, KW_LEN[k]});
                for (int i = 0; i < KW_BYTES; i++) begin
                    if (3'(i) < KW_LEN[k] && b[i] != KW_TEXT[k][i]) begin
                        hit = 1'b0;
                    end
                end
                if (hit && id == 5'd0) begin
                    id = 5'(k + 1);
                end
            end
        end
        return id;
    endfunction

    function automatic token_t mk_tok(input logic [4:0] kind, input logic [4:0] kw,
                                      input col_t start, input col_t len,
                                      input logic [2:0] err, input col_t ecol);
        token_t t;
        t.token_kind  = kind;
        t.keyword_id  = kw;
        t.start_col   = start;
        t.text_len    = len;
        t.error_code  = err;
        t.error_col   = ecol;
        t.last_result = 1'b0;
        return t;
    endfunction

    function automatic token_t mk_word(input kw_buf_t b, input col_t start,
                                       input col_t len, input logic ovf);
        logic [4:0] id;
        id = kw_lookup(b, len, ovf);
        return mk_tok((id != 5'd0) ? K_KW : K_ID, id, start, len, ERR_NONE, 16'd0);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sqll_if.sv -----
`default_nettype none

interface sqll_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_text;

    modport source (output valid, output ch, output has_char, output end_of_text,
                    input ready);
    modport sink (input valid, input ch, input has_char, input end_of_text,
                  output ready);
endinterface

interface sqll_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [4:0]  keyword_id;
    logic [15:0] start_col;
    logic [15:0] text_len;
    logic [2:0]  error_code;
    logic [15:0] error_col;
    logic        last_result;

    modport source (output valid, output token_kind, output keyword_id,
                    output start_col, output text_len, output error_code,
                    output error_col, output last_result, input ready);
    modport sink (input valid, input token_kind, input keyword_id,
                  input start_col, input text_len, input error_code,
                  input error_col, input last_result, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sqll_step.sv -----
`default_nettype none

module sqll_step
    import sqll_pkg::*;
(
    input  logic [7:0] ch,
    input  logic       has_char,
    input  logic       end_of_text,
    input  lex_state_t st,
    input  kw_buf_t    kbuf,
    output lex_state_t st_next,
    output kw_buf_t    kbuf_next,
    output token_t     res [RES_MAX],
    output logic [1:0] res_cnt
);

    // Slots in emission order: token closed by this character, the
    // character's own token, token closed by end of text, then Eof.
    logic [3:0] slot_v;
    token_t     slot_t [4];
    lex_state_t s;
    kw_buf_t    kb;
    logic       consumed;
    logic [7:0] quote;
    logic [1:0] n;

    always_comb
    begin
        s        = st;
        kb       = kbuf;
        slot_v   = '0;
        slot_t   = '{default: '0};
        consumed = 1'b0;
        quote    = (st.mode == MODE_DQ) ? 8'h22 : 8'h27;

        if (has_char)
        begin
            s.col = sat_inc(s.col);
            case (s.mode)
                MODE_WORD:
                begin
                    if (is_alpha(ch) || is_digit(ch) || ch == "_")
                    begin
                        if (s.len < col_t'(KW_BYTES))
                            kb[s.len[2:0]] = upcase(ch);
                        else
                            s.ovf = 1'b1;
                        s.len    = sat_inc(s.len);
                        consumed = 1'b1;
                    end
                    else
                    begin
                        slot_v[0] = 1'b1;
                        slot_t[0] = mk_word(kb, s.start, s.len, s.ovf);
                        s.mode    = MODE_IDLE;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(ch))
                    begin
                        s.len    = sat_inc(s.len);
                        consumed = 1'b1;
                    end
                    else
                    begin
                        slot_v[0] = 1'b1;
                        slot_t[0] = mk_tok(K_NUM, 5'd0, s.start, s.len, ERR_NONE, 16'd0);
                        s.mode    = MODE_IDLE;
                    end
                end
                MODE_DQ, MODE_SQ:
                begin
                    consumed = 1'b1;
                    if (ch == quote)
                    begin
                        slot_v[0] = 1'b1;
                        slot_t[0] = mk_tok(K_STR, 5'd0, s.start, s.len, ERR_NONE, 16'd0);
                        s.mode    = MODE_IDLE;
                    end
                    else
                    begin
                        s.len = sat_inc(s.len);
                    end
                end
                MODE_OP:
                begin
                    slot_v[0] = 1'b1;
                    if (ch == "=")
                    begin
                        slot_t[0] = mk_tok((s.op == OP_BANG) ? K_NEQ :
                                           (s.op == OP_LT) ? K_LTEQ : K_GTEQ,
                                           5'd0, s.start, 16'd2, ERR_NONE, 16'd0);
                        consumed  = 1'b1;
                    end
                    else if (s.op == OP_BANG)
                    begin
                        slot_t[0] = mk_tok(K_INVALID, 5'd0, s.start, 16'd1, ERR_BANG, s.col);
                    end
                    else
                    begin
                        slot_t[0] = mk_tok((s.op == OP_LT) ? K_LT : K_GT, 5'd0, s.start,
                                           16'd1, ERR_NONE, 16'd0);
                    end
                    s.mode = MODE_IDLE;
                    s.op   = OP_NONE;
                end
                default:
                begin
                    s.mode = MODE_IDLE;
                end
            endcase

            if (!consumed)
            begin
                if (is_space(ch))
                begin
                    s.mode = s.mode;
                end
                else if (is_digit(ch))
                begin
                    s.mode  = MODE_NUM;
                    s.start = s.col;
                    s.len   = 16'd1;
                end
                else if (is_alpha(ch))
                begin
                    s.mode  = MODE_WORD;
                    s.start = s.col;
                    s.len   = 16'd1;
                    s.ovf   = 1'b0;
                    kb[0]   = upcase(ch);
                end
                else if (ch == 8'h22 || ch == 8'h27)
                begin
                    s.mode  = (ch == 8'h22) ? MODE_DQ : MODE_SQ;
                    s.start = s.col;
                    s.len   = 16'd0;
                end
                else if (ch == "!" || ch == "<" || ch == ">")
                begin
                    s.mode  = MODE_OP;
                    s.op    = (ch == "!") ? OP_BANG : (ch == "<") ? OP_LT : OP_GT;
                    s.start = s.col;
                    s.len   = 16'd1;
                end
                else if (single_kind(ch) != K_KW)
                begin
                    slot_v[1] = 1'b1;
                    slot_t[1] = mk_tok(single_kind(ch), 5'd0, s.col, 16'd1, ERR_NONE, 16'd0);
                end
                else
                begin
                    slot_v[1] = 1'b1;
                    slot_t[1] = mk_tok(K_ERR, 5'd0, s.col, 16'd1, ERR_BAD_CHAR, s.col);
                end
            end
        end

        if (end_of_text)
        begin
            case (s.mode)
                MODE_WORD:
                begin
                    slot_v[2] = 1'b1;
                    slot_t[2] = mk_word(kb, s.start, s.len, s.ovf);
                end
                MODE_NUM:
                begin
                    slot_v[2] = 1'b1;
                    slot_t[2] = mk_tok(K_NUM, 5'd0, s.start, s.len, ERR_NONE, 16'd0);
                end
                MODE_DQ, MODE_SQ:
                begin
                    slot_v[2] = 1'b1;
                    slot_t[2] = mk_tok(K_STR, 5'd0, s.start, s.len, ERR_OPEN_STR,
                                       sat_inc(s.col));
                end
                MODE_OP:
                begin
                    slot_v[2] = 1'b1;
                    if (s.op == OP_BANG)
                        slot_t[2] = mk_tok(K_INVALID, 5'd0, s.start, 16'd1, ERR_BANG_END,
                                           sat_inc(s.start));
                    else
                        slot_t[2] = mk_tok((s.op == OP_LT) ? K_LT : K_GT, 5'd0, s.start,
                                           16'd1, ERR_NONE, 16'd0);
                end
                default:
                begin
                    slot_v[2] = 1'b0;
                end
            endcase
            slot_v[3] = 1'b1;
            slot_t[3] = mk_tok(K_EOF, 5'd0, sat_inc(s.col), 16'd0, ERR_NONE, 16'd0);
            s.mode    = MODE_IDLE;
            s.op      = OP_NONE;
            s.col     = 16'd0;
            s.start   = 16'd0;
            s.len     = 16'd0;
            s.ovf     = 1'b0;
        end

        st_next   = s;
        kbuf_next = kb;
    end

    // At most three results per character; anything beyond is dropped.
    // The final result of the character carries last_result.
    always_comb
    begin
        res = '{default: '0};
        n   = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (slot_v[i] && n != 2'd3)
            begin
                res[n] = slot_t[i];
                n      = 2'(n + 2'd1);
            end
        end
        if (n != 2'd0)
        begin
            res[2'(n - 2'd1)].last_result = 1'b1;
        end
        res_cnt = n;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sqll_outq.sv -----
`default_nettype none

module sqll_outq
    import sqll_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [1:0] push_cnt,
    input  token_t     push_data [RES_MAX],
    input  logic       pop,
    output logic       head_valid,
    output token_t     head,
    output logic       room,
    output logic [2:0] fill
);

    token_t     mem [Q_DEPTH];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] add;

    assign add      = push ? push_cnt : 2'd0;
    assign wr_next  = 2'(wr_reg + add);
    assign rd_next  = pop ? 2'(rd_reg + 2'd1) : rd_reg;
    assign cnt_next = 3'(cnt_reg + {1'b0, add} - {2'b00, pop});

    assign head_valid = (cnt_reg != 3'd0);
    assign head       = mem[rd_reg];
    // A new request needs space for its worst case of three results.
    assign room       = (cnt_reg <= 3'd1);
    assign fill       = cnt_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (push && 2'(i) < push_cnt)
            begin
                mem[2'(wr_reg + 2'(i))] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sql_subset_lexer_core.sv -----
// Streaming SQL tokenizer. Text bytes arrive on the "text" channel, one
// request per byte, with has_char and end_of_text flags; tokens leave on
// the "tokens" channel with kind, keyword id, start column, length, error
// code and column, and last_result on the final token of a request.
// Each accepted byte is lexed in the same cycle against the lexer state and
// its zero to three results are written into a four-entry result queue, so
// the results of a byte are registered before they reach the token channel.
// A request is taken only while the queue holds at most one result. With
// one result per byte or none, and an attentive receiver, a byte is taken
// every cycle; a byte that yields two or three results holds off the next
// byte, because the queue drains one token per cycle.
// When the receiver stalls, results stay in the queue and the text channel
// drops ready once two results are waiting.
// Reset empties the queue and returns the lexer to idle at column zero.
// The end_of_text request flushes any open token, adds Eof and restarts the
// column count for the next text.
`default_nettype none

module sql_subset_lexer_core
    import sqll_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sqll_text_if.sink    text,
    sqll_token_if.source tokens
);

    lex_state_t st_reg, st_next;
    kw_buf_t    kbuf_reg, kbuf_next;
    token_t     res [RES_MAX];
    logic [1:0] res_cnt;
    logic       accept;
    logic       pop;
    logic       room;
    logic       head_valid;
    token_t     head;
    logic [2:0] fill;

    assign accept     = text.valid && text.ready;
    assign pop        = tokens.valid && tokens.ready;
    assign text.ready = room;

    sqll_step u_step (
        .ch          (text.ch),
        .has_char    (text.has_char),
        .end_of_text (text.end_of_text),
        .st          (st_reg),
        .kbuf        (kbuf_reg),
        .st_next     (st_next),
        .kbuf_next   (kbuf_next),
        .res         (res),
        .res_cnt     (res_cnt)
    );

    sqll_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_cnt   (res_cnt),
        .push_data  (res),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .room       (room),
        .fill       (fill)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{mode: MODE_IDLE, op: OP_NONE, default: '0};
        end
        else if (accept)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kbuf_reg <= kbuf_next;
        end
    end

    assign tokens.valid       = head_valid;
    assign tokens.token_kind  = head.token_kind;
    assign tokens.keyword_id  = head.keyword_id;
    assign tokens.start_col   = head.start_col;
    assign tokens.text_len    = head.text_len;
    assign tokens.error_code  = head.error_code;
    assign tokens.error_col   = head.error_col;
    assign tokens.last_result = head.last_result;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= 3'd4)
        else $error("result queue overfilled");

    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_text |=> st_reg.mode == MODE_IDLE && st_reg.col == 16'd0)
        else $error("end of text did not restart the lexer");

    a_bare_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !text.has_char && !text.end_of_text |=>
            fill == 3'($past(fill) - {2'b00, $past(pop)}))
        else $error("bare request produced results");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_sql_subset_lexer_core.sv -----
module tb_sql_subset_lexer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sqll_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_WORD,
        LX_NUM,
        LX_DQ,
        LX_SQ,
        LX_OP
    } lx_mode_e;

    logic clk;
    logic rst_n;

    sqll_text_if  text_ch ();
    sqll_token_if token_ch ();

    sql_subset_lexer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch.sink),
        .tokens (token_ch.source)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Lexer state held by the predictor.
    lx_mode_e   lx_mode;
    pend_op_t   lx_op;
    col_t       lx_col;
    col_t       lx_start;
    col_t       lx_len;
    logic [7:0] lx_word [7];
    logic       lx_ovf;

    token_t     token_q [$];
    int         fail_count;
    int         token_count;
    int         char_count;
    int         stall_idle;
    bit         idle_on;

    string      kw_names [23] = '{"SELECT", "FROM", "WHERE", "ORDER", "BY", "AND", "OR",
        "CREATE", "TABLE", "INT", "PRIMARY", "KEY", "VARCHAR", "BOOL", "UPDATE", "SET",
        "INSERT", "INTO", "VALUES", "TRUE", "FALSE", "DELETE", "DROP"};

    function automatic col_t bump(input col_t v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic bit alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic push_token(ref token_t toks [$], input logic [4:0] kind,
                              input logic [4:0] kw, input col_t start, input col_t len,
                              input logic [2:0] err, input col_t ecol);
        token_t t;
        t.token_kind  = kind;
        t.keyword_id  = kw;
        t.start_col   = start;
        t.text_len    = len;
        t.error_code  = err;
        t.error_col   = ecol;
        t.last_result = 1'b0;
        if (toks.size() < 3)
            toks = {toks, t};
    endtask

    task automatic push_word(ref token_t toks [$]);
        string s;
        logic [4:0] id;
        id = 5'd0;
        if (!lx_ovf && lx_len <= 16'd7)
        begin
            for (int k = 0; k < 23; k++)
            begin
                s = kw_names[k];
                if (s.len() == lx_len && id == 5'd0)
                begin
                    id = 5'(k + 1);
                    for (int i = 0; i < s.len(); i++)
                        if (s[i] != lx_word[i])
                            id = 5'd0;
                end
            end
        end
        push_token(toks, (id != 5'd0) ? K_KW : K_ID, id, lx_start, lx_len,
                   ERR_NONE, 16'd0);
    endtask

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        case (c)
            ",": return K_COMMA;
            ";": return K_SEMI;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "=": return K_EQ;
            "+": return K_PLUS;
            "-": return K_MINUS;
            "*": return K_STAR;
            "/": return K_SLASH;
            default: return K_KW;
        endcase
    endfunction

    task automatic reset_lexer();
        lx_mode  = LX_IDLE;
        lx_op    = OP_NONE;
        lx_col   = 16'd0;
        lx_start = 16'd0;
        lx_len   = 16'd0;
        lx_ovf   = 1'b0;
        foreach (lx_word[i])
            lx_word[i] = 8'd0;
    endtask

    task automatic lex_char(input logic [7:0] c, input logic has, input logic eot);
        token_t toks [$];
        bit taken;
        logic [4:0] k;
        taken = 0;
        if (has)
        begin
            lx_col = bump(lx_col);
            case (lx_mode)
                LX_WORD:
                    if (alpha(c) || digit(c) || c == "_")
                    begin
                        if (lx_len < 16'd7)
                            lx_word[lx_len] = upper(c);
                        else
                            lx_ovf = 1'b1;
                        lx_len = bump(lx_len);
                        taken = 1;
                    end
                    else
                    begin
                        push_word(toks);
                        lx_mode = LX_IDLE;
                    end
                LX_NUM:
                    if (digit(c))
                    begin
                        lx_len = bump(lx_len);
                        taken = 1;
                    end
                    else
                    begin
                        push_token(toks, K_NUM, 5'd0, lx_start, lx_len, ERR_NONE, 16'd0);
                        lx_mode = LX_IDLE;
                    end
                LX_DQ, LX_SQ:
                begin
                    taken = 1;
                    if (c == ((lx_mode == LX_DQ) ? 8'h22 : 8'h27))
                    begin
                        push_token(toks, K_STR, 5'd0, lx_start, lx_len, ERR_NONE, 16'd0);
                        lx_mode = LX_IDLE;
                    end
                    else
                        lx_len = bump(lx_len);
                end
                LX_OP:
                begin
                    if (c == "=")
                    begin
                        k = (lx_op == OP_BANG) ? K_NEQ : (lx_op == OP_LT) ? K_LTEQ : K_GTEQ;
                        push_token(toks, k, 5'd0, lx_start, 16'd2, ERR_NONE, 16'd0);
                        taken = 1;
                    end
                    else if (lx_op == OP_BANG)
                        push_token(toks, K_INVALID, 5'd0, lx_start, 16'd1, ERR_BANG, lx_col);
                    else
                        push_token(toks, (lx_op == OP_LT) ? K_LT : K_GT, 5'd0, lx_start,
                                   16'd1, ERR_NONE, 16'd0);
                    lx_mode = LX_IDLE;
                    lx_op = OP_NONE;
                end
                default:
                    lx_mode = LX_IDLE;
            endcase
            if (!taken)
            begin
                k = punct_kind(c);
                if (c == " " || (c >= 8'd9 && c <= 8'd13))
                begin
                end
                else if (digit(c))
                begin
                    lx_mode = LX_NUM;
                    lx_start = lx_col;
                    lx_len = 16'd1;
                end
                else if (alpha(c))
                begin
                    lx_mode = LX_WORD;
                    lx_start = lx_col;
                    lx_len = 16'd1;
                    lx_ovf = 1'b0;
                    lx_word[0] = upper(c);
                end
                else if (c == 8'h22 || c == 8'h27)
                begin
                    lx_mode = (c == 8'h22) ? LX_DQ : LX_SQ;
                    lx_start = lx_col;
                    lx_len = 16'd0;
                end
                else if (c == "!" || c == "<" || c == ">")
                begin
                    lx_mode = LX_OP;
                    lx_op = (c == "!") ? OP_BANG : (c == "<") ? OP_LT : OP_GT;
                    lx_start = lx_col;
                    lx_len = 16'd1;
                end
                else if (k != K_KW)
                    push_token(toks, k, 5'd0, lx_col, 16'd1, ERR_NONE, 16'd0);
                else
                    push_token(toks, K_ERR, 5'd0, lx_col, 16'd1, ERR_BAD_CHAR, lx_col);
            end
        end
        if (eot)
        begin
            case (lx_mode)
                LX_WORD: push_word(toks);
                LX_NUM:  push_token(toks, K_NUM, 5'd0, lx_start, lx_len, ERR_NONE, 16'd0);
                LX_DQ, LX_SQ:
                    push_token(toks, K_STR, 5'd0, lx_start, lx_len, ERR_OPEN_STR,
                               bump(lx_col));
                LX_OP:
                    if (lx_op == OP_BANG)
                        push_token(toks, K_INVALID, 5'd0, lx_start, 16'd1, ERR_BANG_END,
                                   bump(lx_start));
                    else
                        push_token(toks, (lx_op == OP_LT) ? K_LT : K_GT, 5'd0, lx_start,
                                   16'd1, ERR_NONE, 16'd0);
                default:
                begin
                end
            endcase
            push_token(toks, K_EOF, 5'd0, bump(lx_col), 16'd0, ERR_NONE, 16'd0);
            lx_mode = LX_IDLE;
            lx_op = OP_NONE;
            lx_col = 16'd0;
            lx_start = 16'd0;
            lx_len = 16'd0;
            lx_ovf = 1'b0;
        end
        if (toks.size() > 0)
            toks[toks.size() - 1].last_result = 1'b1;
        foreach (toks[i])
            token_q = {token_q, toks[i]};
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        if (fail_count <= 30)
            $display("mismatch at token %0d: %s got %0d want %0d", token_count, what,
                     got, want);
    endtask

    // Send one request and update the prediction when it is taken. Valid stays
    // high afterwards so that the next request can follow with no gap.
    task automatic send_char(input logic [7:0] c, input logic has, input logic eot);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.ch          <= c;
        text_ch.has_char    <= has;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        lex_char(c, has, eot);
        char_count++;
    endtask

    task automatic send_text(input string s, input bit eot);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b1, eot && (i == s.len() - 1));
    endtask

    task automatic drain();
        text_ch.valid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sink side: random stalls and the compare.
    always @(posedge clk)
    begin
        token_t want;
        if (!rst_n)
            stall_idle <= 0;
        else
        begin
            if (token_ch.valid && token_ch.ready)
            begin
                token_count++;
                if (token_q.size() == 0)
                    report_mismatch("unexpected token kind", token_ch.token_kind, 16'd0);
                else
                begin
                    want = token_q.pop_front();
                    if (token_ch.token_kind != want.token_kind)
                        report_mismatch("token_kind", token_ch.token_kind, want.token_kind);
                    if (token_ch.keyword_id != want.keyword_id)
                        report_mismatch("keyword_id", token_ch.keyword_id, want.keyword_id);
                    if (token_ch.start_col != want.start_col)
                        report_mismatch("start_col", token_ch.start_col, want.start_col);
                    if (token_ch.text_len != want.text_len)
                        report_mismatch("text_len", token_ch.text_len, want.text_len);
                    if (token_ch.error_code != want.error_code)
                        report_mismatch("error_code", token_ch.error_code, want.error_code);
                    if (token_ch.error_col != want.error_col)
                        report_mismatch("error_col", token_ch.error_col, want.error_col);
                    if (token_ch.last_result != want.last_result)
                        report_mismatch("last_result", token_ch.last_result,
                                        want.last_result);
                end
            end
            if (stall_idle > 0)
            begin
                stall_idle <= stall_idle - 1;
                token_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_idle <= $urandom_range(0, 6);
                token_ch.ready <= 1'b0;
            end
            else
                token_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    int quiet_cycles;
    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_keywords();
        foreach (kw_names[i])
            send_text({kw_names[i], " "}, 0);
        send_text("select From wHeRe x_1 abcdefgh SELECTX", 1);
    endtask

    task automatic test_operators();
        send_text("a,b;(c)=1!=2<3>4+5-6*7/8>=9<=0 'str' \"dq\"", 1);
        send_text("!x !", 1);
        send_text("<", 1);
        send_text(">", 1);
        send_text("\"open", 1);
        send_text("'", 1);
    endtask

    task automatic test_special();
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char("_", 1'b1, 1'b0);
        send_char(8'h41, 1'b0, 1'b0);
        send_char(8'h09, 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b1);
        send_char(8'h00, 1'b0, 1'b1);
    endtask

    function automatic logic [7:0] pick_char();
        string pool;
        pool = "abcxyzSELECTfromWhere019_ ,;()=+-*/!<>'\"\t";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    task automatic test_random(input int count);
        int n;
        string s;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                s = kw_names[$urandom_range(0, 22)];
                for (int i = 0; i < s.len() && n < count; i++, n++)
                    send_char($urandom_range(0, 1) ? s[i] : s[i] + 8'd32, 1'b1, 1'b0);
                send_char(" ", 1'b1, 1'b0);
                n++;
            end
            else
            begin
                send_char(pick_char(), $urandom_range(0, 15) != 0,
                          $urandom_range(0, 24) == 0);
                n++;
            end
        end
        send_char(8'h00, 1'b0, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        idle_on = 1;
        fail_count = 0;
        token_count = 0;
        char_count = 0;
        quiet_cycles = 0;
        text_ch.valid = 1'b0;
        text_ch.ch = 8'd0;
        text_ch.has_char = 1'b0;
        text_ch.end_of_text = 1'b0;
        token_ch.ready = 1'b0;
        reset_lexer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keywords();
        test_operators();
        test_special();
        // The sender holds back until every pending token has come out.
        drain();
        test_random(130);
        idle_on = 0;
        test_random(60);
        drain();
        $display("tb: %0d characters lexed into %0d tokens: keywords, operators, strings,",
                 char_count, token_count);
        $display("tb: error cases and random text with stalls on both channels");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
